// ----- rtl/core/tofh_pkg.sv -----
`default_nettype none

package tofh_pkg;

  localparam int unsigned CFG_W      = 9;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned OFFSET_LSB = 8;
  localparam int unsigned OFFSET_W   = 24;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned IDX_OUT_W  = 10;

  localparam logic [CFG_W-1:0] BIN_WIDTH_RST = 9'd1;

  typedef enum logic [1:0] {
    MODE_HIT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    RES_HIT   = 3'd0,
    RES_DROP  = 3'd1,
    RES_READ  = 3'd2,
    RES_CLEAR = 3'd3,
    RES_NOP   = 3'd4
  } res_e;

  typedef struct packed {
    logic load_in;
    logic load_bw;
    logic div_start;
    logic mem_rd_hit;
    logic mem_rd_idx;
    logic mem_inc;
    logic clr_step;
    logic out_load;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic drop;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/tofh_div.sv -----
`default_nettype none

module tofh_div import tofh_pkg::*; #(
  parameter int unsigned DVD_W = 24,
  parameter int unsigned DVS_W = 25
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quot_q;

  logic [DVS_W:0] shifted;
  logic [DVS_W:0] diff;
  logic           fits;

  // restoring division, one quotient bit per cycle, msb first
  assign shifted = {rem_q, quot_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign fits    = (shifted >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(DVD_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quot_q <= {quot_q[DVD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- rtl/core/tofh_dp.sv -----
`default_nettype none

module tofh_dp import tofh_pkg::*; #(
  parameter int unsigned NUM_BINS     = 1024,
  parameter int unsigned TICKS_PER_US = 2000
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic [WORD_W-1:0]    hit_word_i,
  input  wire logic [IDX_OUT_W-1:0] read_index_i,
  input  wire logic                 out_stall_i,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  output logic                      out_valid_o,
  output logic      [IDX_OUT_W-1:0] bin_index_o,
  output logic      [CNT_W-1:0]     bin_count_o,
  output logic      [IDX_OUT_W-1:0] largest_bin_o,
  output logic                      hit_dropped_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_BINS);
  localparam int unsigned TICK_W = $clog2(TICKS_PER_US + 1);
  localparam int unsigned BW_W   = CFG_W + TICK_W;
  localparam int unsigned BIN_W  = OFFSET_W + 1;
  localparam logic [TICK_W-1:0] TICKS_C = TICK_W'(TICKS_PER_US);

  logic [CFG_W-1:0]     bin_width_q;
  logic [OFFSET_W-1:0]  offset_q;
  logic [IDX_OUT_W-1:0] read_index_q;
  logic                 rd_ok_q;
  logic [BW_W-1:0]      bw_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [IDX_W-1:0]     highest_q;
  logic [IDX_W-1:0]     clr_idx_q;
  logic [CNT_W-1:0]     rd_data_q;
  logic [CNT_W-1:0]     mem_q [NUM_BINS];

  logic                 out_valid_q;
  logic [IDX_OUT_W-1:0] bin_index_q;
  logic [CNT_W-1:0]     bin_count_q;
  logic [IDX_OUT_W-1:0] largest_bin_q;
  logic                 hit_dropped_q;

  logic                 div_done;
  logic [OFFSET_W-1:0]  quot;
  logic [BIN_W-1:0]     bin;
  logic                 drop;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     wr_addr;
  logic [CNT_W-1:0]     wr_data;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 clr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= BIN_WIDTH_RST;
    end else if (cfg_we_i) begin
      bin_width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      offset_q     <= hit_word_i[OFFSET_LSB +: OFFSET_W];
      read_index_q <= read_index_i;
      rd_ok_q      <= (32'(read_index_i) < 32'(NUM_BINS));
    end
    if (cmd_i.load_bw) begin
      bw_q <= BW_W'(bin_width_q) * BW_W'(TICKS_C);
    end
  end

  tofh_div #(
    .DVD_W (OFFSET_W),
    .DVS_W (BW_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (offset_q),
    .divisor_i  (bw_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // bin zero is never used, so the quotient is offset by one
  assign bin  = BIN_W'(quot) + BIN_W'(1);
  assign drop = (bw_q == '0) || (bin >= BIN_W'(NUM_BINS));

  assign rd_addr = cmd_i.mem_rd_hit ? bin[IDX_W-1:0] : IDX_W'(read_index_q);
  assign cnt_inc = (rd_data_q == '1) ? rd_data_q : rd_data_q + CNT_W'(1);
  assign mem_we  = cmd_i.clr_step || cmd_i.mem_inc;
  assign wr_addr = cmd_i.clr_step ? clr_idx_q : hit_idx_q;
  assign wr_data = cmd_i.clr_step ? '0 : cnt_inc;
  assign clr_last = (clr_idx_q == IDX_W'(NUM_BINS - 1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd_hit || cmd_i.mem_rd_idx) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd_hit) begin
      hit_idx_q <= bin[IDX_W-1:0];
    end
    if (cmd_i.mem_inc) begin
      cnt_q <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= '0;
      clr_idx_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        highest_q <= '0;
        clr_idx_q <= clr_last ? '0 : clr_idx_q + IDX_W'(1);
      end else if (cmd_i.mem_inc && (hit_idx_q > highest_q)) begin
        highest_q <= hit_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.res)
        RES_HIT: begin
          bin_index_q   <= IDX_OUT_W'(hit_idx_q);
          bin_count_q   <= cnt_q;
          largest_bin_q <= IDX_OUT_W'(highest_q);
          hit_dropped_q <= 1'b0;
        end
        RES_DROP: begin
          bin_index_q   <= '0;
          bin_count_q   <= '0;
          largest_bin_q <= IDX_OUT_W'(highest_q);
          hit_dropped_q <= 1'b1;
        end
        RES_READ: begin
          bin_index_q   <= read_index_q;
          bin_count_q   <= rd_ok_q ? rd_data_q : '0;
          largest_bin_q <= IDX_OUT_W'(highest_q);
          hit_dropped_q <= 1'b0;
        end
        RES_CLEAR: begin
          bin_index_q   <= '0;
          bin_count_q   <= '0;
          largest_bin_q <= '0;
          hit_dropped_q <= 1'b0;
        end
        default: begin
          bin_index_q   <= '0;
          bin_count_q   <= '0;
          largest_bin_q <= IDX_OUT_W'(highest_q);
          hit_dropped_q <= 1'b0;
        end
      endcase
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.drop     = drop;
  assign sts_o.clr_last = clr_last;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign bin_index_o   = bin_index_q;
  assign bin_count_o   = bin_count_q;
  assign largest_bin_o = largest_bin_q;
  assign hit_dropped_o = hit_dropped_q;

endmodule

`default_nettype wire

// ----- rtl/core/tofh_ctrl.sv -----
`default_nettype none

module tofh_ctrl import tofh_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] mode_i,
  input  wire sts_t       sts_i,
  output logic            in_stall_o,
  output cmd_t            cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_MUL,
    S_DIVS,
    S_DIVW,
    S_CHK,
    S_INC,
    S_RD,
    S_CLR,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;
  mode_e  mode;
  cmd_t   cmd;

  assign mode = mode_e'(mode_i);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd     = '0;
    cmd.res = res_q;
    unique case (state_q)
      S_INIT: begin
        // clearing pass over the counter store after reset
        cmd.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          unique case (mode)
            MODE_HIT:   state_d = S_MUL;
            MODE_READ:  state_d = S_RD;
            MODE_CLEAR: state_d = S_CLR;
            MODE_NOP: begin
              res_d   = RES_NOP;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.load_bw = 1'b1;
        state_d     = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_d       = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.drop) begin
          res_d   = RES_DROP;
          state_d = S_OUT;
        end else begin
          cmd.mem_rd_hit = 1'b1;
          state_d        = S_INC;
        end
      end
      S_INC: begin
        cmd.mem_inc = 1'b1;
        res_d       = RES_HIT;
        state_d     = S_OUT;
      end
      S_RD: begin
        cmd.mem_rd_idx = 1'b1;
        res_d          = RES_READ;
        state_d        = S_OUT;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          res_d   = RES_CLEAR;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      res_q   <= RES_NOP;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

  // one item at a time: nothing more is taken right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous one in flight");

  // the divider only finishes while the controller waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIVW))
    else $error("divider done outside wait state");

  // counter write-back always follows its read in the previous cycle
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_inc |-> $past(cmd.mem_rd_hit))
    else $error("counter increment without preceding read");

endmodule

`default_nettype wire

// ----- rtl/core/time_of_flight_histogrammer_core.sv -----
// time-of-flight histogram core
// input channel (in_valid_i / in_stall_o) carries mode_i, hit_word_i and read_index_i.
// mode hit bins the offset in hit_word_i[31:8] at offset / (bin_width * TICKS_PER_US) + 1,
// mode read returns one counter, mode clear zeroes every counter and the largest bin.
// output channel (out_valid_o / out_stall_i) returns exactly one result per item.
// the user writes bin_width (cfg_we_i / cfg_wdata_i) while the core is idle; not checked.
// one item is in work at a time; in_stall_o is low only while the core waits for one.
// a hit runs the width multiply, the bit-serial divider, the counter read-modify-write
// and the output load; a read does one counter read and the output load, and a clear
// writes one counter per cycle over the whole store before its output load.
// out of reset the core runs a clearing pass over the counter store
// with in_stall_o high; bin_width resets to 1.
// a finished result sits in the output register; the next item may be accepted while
// it waits, and when out_stall_i stays high the core holds its next result until the
// register frees up.
`default_nettype none

module time_of_flight_histogrammer_core import tofh_pkg::*; #(
  parameter int unsigned NUM_BINS     = 1024,
  parameter int unsigned TICKS_PER_US = 2000
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [WORD_W-1:0]    hit_word_i,
  input  wire logic [IDX_OUT_W-1:0] read_index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [IDX_OUT_W-1:0] bin_index_o,
  output logic      [CNT_W-1:0]     bin_count_o,
  output logic      [IDX_OUT_W-1:0] largest_bin_o,
  output logic                      hit_dropped_o
);

  cmd_t cmd;
  sts_t sts;

  tofh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  tofh_dp #(
    .NUM_BINS     (NUM_BINS),
    .TICKS_PER_US (TICKS_PER_US)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .hit_word_i    (hit_word_i),
    .read_index_i  (read_index_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .bin_index_o   (bin_index_o),
    .bin_count_o   (bin_count_o),
    .largest_bin_o (largest_bin_o),
    .hit_dropped_o (hit_dropped_o)
  );

endmodule

`default_nettype wire
